>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_dp and the top level lru_key_value_cache.
package lkvc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 4;
  localparam int unsigned ENTRIES_DEF = 8;

  localparam logic [CAP_W-1:0]         CAP_RESET  = 4'd8;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // register a new request
    logic lookup;   // compare cycle: pick target, read data
    logic commit;   // update cycle: write entries, emit result
  } cmd_t;

endpackage

>>> rtl/lkvc_ctrl.sv
// Sequencer for the LRU key-value cache: idle, lookup, update.
// Depends on lkvc_pkg for state and command types.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic idle_o
);

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q == S_LOOKUP);
  assign idle_o = (state_q == S_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        // a new item may enter while this one commits
        state_d = start_i ? S_LOOKUP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.lookup  = (state_q == S_LOOKUP);
  assign cmd_o.commit  = (state_q == S_UPDATE);

endmodule

>>> rtl/lkvc_dp.sv
// Datapath of the LRU key-value cache: key cells, recency ranks, data memory.
// Depends on lkvc_pkg; driven by lkvc_ctrl commands.
module lkvc_dp import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  req_t             req_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output rsp_t             rsp_o,
  output logic             done_o
);

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RW   = IW;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  // entry state
  logic [ENTRIES-1:0]     valid_q;
  logic [DATA_W-1:0]      key_q  [ENTRIES];
  logic [RW-1:0]          rank_q [ENTRIES];
  logic [DATA_W-1:0]      mem_q  [ENTRIES];
  logic [CW-1:0]          count_q;
  logic [CAP_W-1:0]       cap_q;

  req_t                   req_q;

  // lookup results, held for the update cycle
  logic [ENTRIES-1:0]     tgt_oh_q;
  logic [IW-1:0]          tgt_idx_q;
  logic [RW-1:0]          tgt_rank_q;
  logic                   hit_q, fresh_q, evict_q, touch_q, wr_key_q, wr_data_q;
  logic [DATA_W-1:0]      ev_key_q;
  logic [DATA_W-1:0]      rd_data_q;

  rsp_t                   rsp_q;
  logic                   done_q;

  // lookup logic
  logic [ENTRIES-1:0]     match_v, hit_oh, free_oh, vict_v, vict_oh, tgt_oh;
  logic [IW-1:0]          hit_idx, tgt_idx;
  logic [RW-1:0]          tgt_rank, lru_rank;
  logic [DATA_W-1:0]      vict_key;
  logic [CMPW-1:0]        cap_eff, count_ext;
  logic                   any_hit, any_free, any_vict, is_set, fill, fresh, evict;

  assign is_set    = (req_q.action == ACT_SET);
  assign lru_rank  = RW'(count_q - CW'(1));
  assign count_ext = CMPW'(count_q);

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap_q) > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end else begin
      cap_eff = CMPW'(cap_q);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_v[i] = valid_q[i] && (key_q[i] == req_q.lookup_key);
      // ranks of valid entries are 0..count-1, so the LRU one holds count-1
      vict_v[i]  = valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  // lowest set bit of each vector
  assign hit_oh  = match_v & (~match_v + ENTRIES'(1));
  assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));
  assign vict_oh = vict_v & (~vict_v + ENTRIES'(1));

  assign any_hit  = |match_v;
  assign any_free = ~&valid_q;
  assign any_vict = |vict_v;

  assign fill  = !any_hit && is_set && (count_ext < cap_eff) && any_free;
  assign fresh = fill;
  assign evict = !any_hit && is_set && !fill && any_vict;

  always_comb begin
    if (any_hit) begin
      tgt_oh = hit_oh;
    end else if (fill) begin
      tgt_oh = free_oh;
    end else if (evict) begin
      tgt_oh = vict_oh;
    end else begin
      tgt_oh = '0;
    end
  end

  // one-hot to index and one-hot selects
  always_comb begin
    hit_idx  = '0;
    tgt_idx  = '0;
    tgt_rank = '0;
    vict_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i])  hit_idx  = hit_idx | IW'(i);
      if (tgt_oh[i])  tgt_idx  = tgt_idx | IW'(i);
      if (tgt_oh[i])  tgt_rank = tgt_rank | rank_q[i];
      if (vict_oh[i]) vict_key = vict_key | key_q[i];
    end
  end

  // request and lookup registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.lookup) begin
      tgt_oh_q   <= tgt_oh;
      tgt_idx_q  <= tgt_idx;
      tgt_rank_q <= tgt_rank;
      hit_q      <= any_hit;
      fresh_q    <= fresh;
      evict_q    <= evict;
      touch_q    <= any_hit || fill || evict;
      wr_key_q   <= fill || evict;
      wr_data_q  <= is_set && (any_hit || fill || evict);
      ev_key_q   <= vict_key;
    end
  end

  // data memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_data_q) begin
      mem_q[tgt_idx_q] <= req_q.write_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rd_data_q <= mem_q[hit_idx];
    end
  end

  // key cells, written only on fill or eviction
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.commit && wr_key_q && tgt_oh_q[i]) begin
        key_q[i] <= req_q.lookup_key;
      end
    end
  end

  // valid bits, ranks, count, capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      cap_q   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        if (fresh_q) begin
          valid_q <= valid_q | tgt_oh_q;
          count_q <= count_q + CW'(1);
        end
        if (touch_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_oh_q[i]) begin
              rank_q[i] <= '0;
            end else if (valid_q[i] && (fresh_q || (rank_q[i] < tgt_rank_q))) begin
              rank_q[i] <= rank_q[i] + RW'(1);
            end
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.hit         <= hit_q;
      rsp_q.read_value  <= (hit_q && (req_q.action == ACT_GET)) ? rd_data_q : MISS_VALUE;
      rsp_q.evicted     <= evict_q;
      rsp_q.evicted_key <= evict_q ? ev_key_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

>>> rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp.
//
// Channel    Direction  Transfer condition            Payload
// request    in         start && !busy                req_i   (req_t)
// result     out        done_o (one cycle, no stall)  rsp_o   (rsp_t)
// config     in         cfg_valid_i && cfg_ready_o    cfg_data_i (capacity)
//
// An item passes a lookup state, the parallel key and rank compare over all
// entries, then an update state for the entry and recency. A new start is taken
// in the update cycle, so a new item can enter while the last one commits.
// The result shows on rsp_o with done_o for one cycle, the cycle after update.
// The receiver cannot stall; busy only covers the compare cycle.
// Reset clears valid bits, ranks, fill count and sets capacity to 8 at once;
// there is no clearing pass. Key and data storage is not reset.
// Config is taken while no item is in flight (cfg_ready_o).
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  cmd_t cmd;
  logic idle;

  lkvc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .idle_o  (idle)
  );

  // capacity register write: one transfer per valid/ready pair
  assign cfg_ready_o = idle;

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o),
    .done_o     (done_o)
  );

  // results never come back to back
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back results");

  // an accepted item always occupies the compare cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("compare cycle skipped");

  // an eviction only happens on a miss
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.evicted) |-> !rsp_o.hit)
    else $error("eviction on a hit");

  // a miss never returns stored data and a non-eviction reports key zero
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.hit) |-> (rsp_o.read_value == MISS_VALUE))
    else $error("miss returned data");

  a_no_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.evicted) |-> (rsp_o.evicted_key == '0))
    else $error("evicted key without eviction");

endmodule

>>> test/lkvc_checker.sv
// Scoreboard for the LRU key-value cache: tracks the capacity register and the
// cache contents, predicts every result and compares it. Depends on lkvc_pkg.
module lkvc_checker import lkvc_pkg::*; #(
  parameter int unsigned SLOTS = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  req_t             req_i,
  input  logic             done_i,
  input  rsp_t             rsp_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                     slot_valid [SLOTS];
  logic signed [DATA_W-1:0] slot_key   [SLOTS];
  logic signed [DATA_W-1:0] slot_data  [SLOTS];
  logic [RANK_W-1:0]        slot_rank  [SLOTS];
  logic [CAP_W-1:0]         capacity;
  rsp_t                     expected_rsp_q [$];
  int                       err_count = 0;

  // Rank 0 is most recent; a fresh slot counts as older than every entry.
  function automatic void promote_slot(int e, bit fresh);
    int limit;
    limit = fresh ? int'(SLOTS) : int'(slot_rank[e]);
    for (int i = 0; i < SLOTS; i++) begin
      if (i != e && slot_valid[i] && int'(slot_rank[i]) < limit) begin
        slot_rank[i] = slot_rank[i] + 1'b1;
      end
    end
    slot_rank[e] = '0;
  endfunction

  function automatic rsp_t cache_access(req_t rq);
    rsp_t r;
    int   cap;
    int   fill;
    int   found;
    int   free_idx;
    int   victim;
    r.hit         = 1'b0;
    r.read_value  = MISS_VALUE;
    r.evicted     = 1'b0;
    r.evicted_key = '0;
    // zero behaves as one, anything past the array saturates
    cap = (capacity == '0) ? 1 : int'(capacity);
    if (cap > SLOTS) cap = SLOTS;
    fill     = 0;
    found    = -1;
    free_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) begin
        fill++;
        if (found < 0 && slot_key[i] == rq.lookup_key) found = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (rq.action == ACT_SET) slot_data[found] = rq.write_value;
      else r.read_value = slot_data[found];
      promote_slot(found, 1'b0);
    end else if (rq.action == ACT_SET) begin
      if (fill < cap && free_idx >= 0) begin
        slot_valid[free_idx] = 1'b1;
        slot_key[free_idx]   = rq.lookup_key;
        slot_data[free_idx]  = rq.write_value;
        promote_slot(free_idx, 1'b1);
      end else begin
        // oldest rank wins, lowest index on a tie
        victim = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          r.evicted         = 1'b1;
          r.evicted_key     = slot_key[victim];
          slot_key[victim]  = rq.lookup_key;
          slot_data[victim] = rq.write_value;
          promote_slot(victim, 1'b0);
        end
      end
    end
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      capacity = CAP_RESET;
      expected_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          flag_error("result with no request outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.hit !== want.hit)
            flag_error($sformatf("hit %0b, want %0b", rsp_i.hit, want.hit));
          if (rsp_i.read_value !== want.read_value)
            flag_error($sformatf("read_value %0d, want %0d",
                                 rsp_i.read_value, want.read_value));
          if (rsp_i.evicted !== want.evicted)
            flag_error($sformatf("evicted %0b, want %0b", rsp_i.evicted, want.evicted));
          if (rsp_i.evicted_key !== want.evicted_key)
            flag_error($sformatf("evicted_key %0d, want %0d",
                                 rsp_i.evicted_key, want.evicted_key));
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(cache_access(req_i));
      pending_o <= expected_rsp_q.size();
    end
    errors_o <= err_count;
  end

endmodule

>>> test/testbench.sv
// Top of the LRU key-value cache test: clock, reset, request and capacity
// stimulus, and the verdict. Depends on lkvc_pkg, lru_key_value_cache, lkvc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'h7fff_ffff;

  // every block input has a known value from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  req_t             req_i       = '0;
  logic             cfg_valid_i = 1'b0;
  logic [CAP_W-1:0] cfg_data_i  = '0;
  logic             busy;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_ready_o;
  int               pending;
  int               errors;
  bit               gaps_on = 1'b1;

  always #6 clk_i = ~clk_i;

  lru_key_value_cache i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  lkvc_checker #(.SLOTS(ENTRIES_DEF)) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req_i),
    .done_i     (done_o),
    .rsp_i      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // One get or set. Called right after a rising edge. With no gap, start stays
  // high from the previous transfer so back-to-back requests are never broken
  // up by a low/high pair in the same step.
  task automatic send_access(logic act, logic signed [DATA_W-1:0] key,
                             logic signed [DATA_W-1:0] val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{action: act, lookup_key: key, write_value: val};
    // busy is sampled before the edge updates it: transfer when it reads low
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off until every predicted result has come back. The first edge lets
  // the checker's count catch up with a transfer made at the current edge.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Capacity is only changed with the cache idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    // Random phases: the cache still holds three entries when these begin, so
    // the first ones grow it, 15 saturates at the array size, and the later,
    // smaller settings run with more entries than the capacity allows.
    logic [CAP_W-1:0]         phase_cap [10] = '{4'd5, 4'd7, 4'd15, 4'd8, 4'd4,
                                                 4'd1, 4'd0, 4'd2, 4'd6, 4'd8};
    logic signed [DATA_W-1:0] key_pool [12];
    logic signed [DATA_W-1:0] key;
    int                       pool_n;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed. Entries are never dropped, so the small capacities come first,
    // while the cache is still empty.
    write_capacity(4'd1);
    send_access(ACT_GET, '0, -1);              // empty cache, value ignored
    send_access(ACT_SET, KEY_MIN, KEY_MAX);
    send_access(ACT_SET, KEY_MIN, KEY_MIN);    // update in place, no eviction
    send_access(ACT_GET, KEY_MIN, '0);
    send_access(ACT_SET, KEY_MAX, '0);         // full at one entry: evicts
    write_capacity(4'd0);                      // zero acts as one
    send_access(ACT_SET, -1, -1);
    send_access(ACT_GET, -1, KEY_MAX);
    send_access(ACT_GET, KEY_MAX, '0);
    write_capacity(4'd3);
    send_access(ACT_SET, 32'sd0, 32'sd1);
    send_access(ACT_SET, 32'sd1, 32'sd2);
    send_access(ACT_GET, -1, '0);              // get hit refreshes recency
    send_access(ACT_SET, 32'sd2, 32'sd3);      // evicts key 0, not key -1
    send_access(ACT_GET, 32'sd0, '0);
    send_access(ACT_GET, 32'sd1, '0);
    write_capacity(4'd2);                      // below the three held
    send_access(ACT_SET, 32'sd3, 32'sd4);
    send_access(ACT_SET, 32'sd4, 32'sd5);
    send_access(ACT_GET, 32'sd2, '0);
    send_access(ACT_SET, 32'sd2, 32'sd7);

    foreach (phase_cap[p]) begin
      write_capacity(phase_cap[p]);
      // about one phase in four runs back to back
      gaps_on = ($urandom_range(0, 3) != 0);
      // small key pool so gets hit and sets collide; a few extremes mixed in
      pool_n = $urandom_range(2, 12);
      foreach (key_pool[k]) begin
        case ($urandom_range(0, 7))
          0:       key_pool[k] = '0;
          1:       key_pool[k] = -1;
          2:       key_pool[k] = KEY_MIN;
          3:       key_pool[k] = KEY_MAX;
          default: key_pool[k] = $urandom;
        endcase
      end
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 39) == 0) wait_idle();
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_n - 1)]
                                         : $urandom;
        send_access($urandom_range(0, 1) ? ACT_SET : ACT_GET, key, $urandom);
      end
    end

    wait_idle();
    // catch any stray result after the last expected one
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: a run that does not finish in time is reported as failing.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
